### design/mcf_pkg.sv
// ----------------------------------------------------------------------------
// mcf_pkg: shared types and constants of the mailbox command framer
// Transaction payloads, the command queue entry and the result codes.
// ----------------------------------------------------------------------------
package mcf_pkg;

   localparam int unsigned BUFFER_BYTES_DEF = 255;
   localparam int unsigned TX_OVERHEAD      = 6;
   localparam int unsigned RX_OVERHEAD      = 5;
   localparam int unsigned CMD_DEPTH        = 4;
   localparam int unsigned SLOT_COUNT       = 8;

   // Reply status codes
   localparam logic [7:0] STATUS_OK      = 8'h00;
   localparam logic [7:0] STATUS_NO_DATA = 8'h01;

   typedef enum logic [1:0] {
      KIND_TX      = 2'd0,
      KIND_RX      = 2'd1,
      KIND_VERDICT = 2'd2
   } mcf_kind_type;

   typedef enum logic [2:0] {
      VERDICT_OK      = 3'd0,
      VERDICT_NO_DATA = 3'd1,
      VERDICT_CSUM    = 3'd2,
      VERDICT_DEV_ERR = 3'd3,
      VERDICT_TOO_LONG = 3'd4
   } mcf_verdict_type;

   // Result slots of one queue entry, in emission order
   typedef enum logic [2:0] {
      SLOT_LEN     = 3'd0,
      SLOT_MBOX    = 3'd1,
      SLOT_CMD     = 3'd2,
      SLOT_SEQ     = 3'd3,
      SLOT_DATA    = 3'd4,
      SLOT_CHK_HI  = 3'd5,
      SLOT_CHK_LO  = 3'd6,
      SLOT_VERDICT = 3'd7
   } mcf_slot_type;

   typedef struct packed {
      logic       mode;
      logic       frame_start;
      logic [7:0] data_byte;
      logic [7:0] command;
      logic [7:0] mailbox;
      logic [7:0] payload_len;
   } mcf_req_type;

   typedef struct packed {
      logic [7:0]      out_byte;
      mcf_kind_type    kind;
      mcf_verdict_type verdict;
      logic            last_of_run;
   } mcf_rsp_type;

   typedef struct packed {
      logic [SLOT_COUNT-1:0] mask;
      logic [7:0]            len_byte;
      logic [7:0]            mailbox;
      logic [7:0]            command;
      logic [7:0]            seq;
      logic [7:0]            data;
      logic                  rx_data;
      logic [15:0]           check;
      mcf_verdict_type       verdict;
   } mcf_cmd_type;

   // Add a byte into the high half at odd positions, the low half at even ones
   function automatic logic [15:0] csum_add(logic [15:0] sum, logic odd, logic [7:0] b);
      logic [15:0] addend;
      addend = odd ? {b, 8'h00} : {8'h00, b};
      return sum + addend;
   endfunction

endpackage

### design/mcf_front.sv
// ----------------------------------------------------------------------------
// mcf_front: frame tracking and classification
// Holds the frame state, checks receive bytes and queues one command entry
// for each accepted transaction that produces results.
// ----------------------------------------------------------------------------
module mcf_front #(
   parameter int unsigned BUFFER_BYTES = mcf_pkg::BUFFER_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  mcf_pkg::mcf_req_type req_data,
   input  logic                 csr_write_en,
   input  logic [7:0]           csr_write_data,
   input  logic                 q_full,
   output logic                 q_push,
   output mcf_pkg::mcf_cmd_type q_entry
);

   localparam logic [8:0] TX_LIMIT = 9'(BUFFER_BYTES - mcf_pkg::TX_OVERHEAD);
   localparam logic [8:0] RX_LIMIT = 9'(BUFFER_BYTES - mcf_pkg::RX_OVERHEAD);

   logic [7:0]  seq_ff, seq_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  chk_hi_ff, chk_hi_in;
   logic        active_ff, active_in;
   logic        fmode_ff, fmode_in;
   logic [7:0]  query_ff;

   logic        accept;
   logic [8:0]  req_len9;
   logic [8:0]  pos9;
   logic [8:0]  len9;
   logic [15:0] hdr_sum;
   logic [15:0] first_sum;
   logic [15:0] pay_sum;
   logic [15:0] want;
   mcf_pkg::mcf_verdict_type rx_verdict;

   assign accept   = req_push && !q_full;
   assign req_len9 = {1'b0, req_data.payload_len};
   assign pos9     = {1'b0, pos_ff};
   assign len9     = {1'b0, len_ff};
   assign hdr_sum  = mcf_pkg::csum_add(
                        mcf_pkg::csum_add(
                           mcf_pkg::csum_add(16'h0000, 1'b1, req_data.mailbox),
                           1'b0, req_data.command),
                        1'b1, seq_ff);
   assign first_sum = mcf_pkg::csum_add(hdr_sum, 1'b0, req_data.data_byte);
   assign pay_sum   = mcf_pkg::csum_add(sum_ff, pos_ff[0], req_data.data_byte);
   assign want      = ~sum_ff;

   always_comb begin
      if (want != {chk_hi_ff, req_data.data_byte}) begin
         rx_verdict = mcf_pkg::VERDICT_CSUM;
      end else if (status_ff != mcf_pkg::STATUS_OK) begin
         rx_verdict = (cmd_ff == query_ff || status_ff == mcf_pkg::STATUS_NO_DATA) ?
                      mcf_pkg::VERDICT_NO_DATA : mcf_pkg::VERDICT_DEV_ERR;
      end else begin
         rx_verdict = mcf_pkg::VERDICT_OK;
      end
   end

   always_comb begin
      seq_in    = seq_ff;
      sum_in    = sum_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      cmd_in    = cmd_ff;
      status_in = status_ff;
      chk_hi_in = chk_hi_ff;
      active_in = active_ff;
      fmode_in  = fmode_ff;
      q_entry          = '0;
      q_entry.len_byte = req_data.payload_len + 8'd5;
      q_entry.mailbox  = req_data.mailbox;
      q_entry.command  = req_data.command;
      q_entry.seq      = seq_ff;
      q_entry.data     = req_data.data_byte;
      q_entry.rx_data  = req_data.mode;
      q_entry.verdict  = mcf_pkg::VERDICT_OK;
      if (accept) begin
         if (req_data.frame_start) begin
            active_in = 1'b0;
            fmode_in  = req_data.mode;
            cmd_in    = req_data.command;
            sum_in    = 16'h0000;
            status_in = mcf_pkg::STATUS_OK;
            chk_hi_in = 8'h00;
            if (!req_data.mode) begin
               if (req_len9 > TX_LIMIT) begin
                  q_entry.mask[mcf_pkg::SLOT_VERDICT] = 1'b1;
                  q_entry.verdict = mcf_pkg::VERDICT_TOO_LONG;
               end else begin
                  seq_in = seq_ff + 8'd1;
                  len_in = req_data.payload_len;
                  q_entry.mask[mcf_pkg::SLOT_LEN]  = 1'b1;
                  q_entry.mask[mcf_pkg::SLOT_MBOX] = 1'b1;
                  q_entry.mask[mcf_pkg::SLOT_CMD]  = 1'b1;
                  q_entry.mask[mcf_pkg::SLOT_SEQ]  = 1'b1;
                  if (req_data.payload_len == 8'd0) begin
                     // empty request: header and check at once
                     sum_in = hdr_sum;
                     pos_in = 8'd4;
                     q_entry.check = ~hdr_sum;
                     q_entry.mask[mcf_pkg::SLOT_CHK_HI] = 1'b1;
                     q_entry.mask[mcf_pkg::SLOT_CHK_LO] = 1'b1;
                  end else begin
                     sum_in    = first_sum;
                     pos_in    = 8'd5;
                     active_in = 1'b1;
                     q_entry.mask[mcf_pkg::SLOT_DATA] = 1'b1;
                     q_entry.check = ~first_sum;
                     if (req_data.payload_len == 8'd1) begin
                        active_in = 1'b0;
                        q_entry.mask[mcf_pkg::SLOT_CHK_HI] = 1'b1;
                        q_entry.mask[mcf_pkg::SLOT_CHK_LO] = 1'b1;
                     end
                  end
               end
            end else begin
               if (req_len9 > RX_LIMIT) begin
                  q_entry.mask[mcf_pkg::SLOT_VERDICT] = 1'b1;
                  q_entry.verdict = mcf_pkg::VERDICT_TOO_LONG;
               end else begin
                  // length byte of the reply: counted, not summed
                  len_in    = req_data.payload_len;
                  pos_in    = 8'd1;
                  active_in = 1'b1;
               end
            end
         end else if (active_ff && req_data.mode == fmode_ff) begin
            pos_in = pos_ff + 8'd1;
            if (!fmode_ff) begin
               sum_in = pay_sum;
               q_entry.mask[mcf_pkg::SLOT_DATA] = 1'b1;
               q_entry.check = ~pay_sum;
               if (pos9 + 9'd1 >= len9 + 9'd4) begin
                  active_in = 1'b0;
                  q_entry.mask[mcf_pkg::SLOT_CHK_HI] = 1'b1;
                  q_entry.mask[mcf_pkg::SLOT_CHK_LO] = 1'b1;
               end
            end else if (pos_ff == 8'd0) begin
               // length byte: skip
               sum_in = sum_ff;
            end else if (pos9 < len9 + 9'd3) begin
               sum_in = pay_sum;
               if (pos_ff == 8'd2) begin
                  status_in = req_data.data_byte;
               end
               if (pos_ff >= 8'd3) begin
                  q_entry.mask[mcf_pkg::SLOT_DATA] = 1'b1;
               end
            end else if (pos9 == len9 + 9'd3) begin
               chk_hi_in = req_data.data_byte;
            end else begin
               active_in = 1'b0;
               q_entry.mask[mcf_pkg::SLOT_VERDICT] = 1'b1;
               q_entry.verdict = rx_verdict;
            end
         end
      end
   end

   assign q_push = accept && (q_entry.mask != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= '0;
         sum_ff    <= '0;
         pos_ff    <= '0;
         len_ff    <= '0;
         cmd_ff    <= '0;
         status_ff <= '0;
         chk_hi_ff <= '0;
         active_ff <= 1'b0;
         fmode_ff  <= 1'b0;
         query_ff  <= '0;
      end else begin
         seq_ff    <= seq_in;
         sum_ff    <= sum_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         cmd_ff    <= cmd_in;
         status_ff <= status_in;
         chk_hi_ff <= chk_hi_in;
         active_ff <= active_in;
         fmode_ff  <= fmode_in;
         if (csr_write_en) begin
            query_ff <= csr_write_data;
         end
      end
   end

endmodule

### design/mcf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mcf_cmd_fifo: command queue between front and back
// Short register queue; the head entry is presented directly.
// ----------------------------------------------------------------------------
module mcf_cmd_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mcf_pkg::mcf_cmd_type push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output mcf_pkg::mcf_cmd_type head
);

   localparam int unsigned DEPTH = mcf_pkg::CMD_DEPTH;
   localparam int unsigned PW    = $clog2(DEPTH);
   localparam int unsigned CW    = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   mcf_pkg::mcf_cmd_type store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      priority if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("command queue pushed while full");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff < FULL_CNT)
      else $error("command queue count out of range after pop");

endmodule

### design/mcf_back.sv
// ----------------------------------------------------------------------------
// mcf_back: result sequencer
// Walks the pending slots of the head command into the output register,
// one result per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module mcf_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  mcf_pkg::mcf_cmd_type q_head,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output mcf_pkg::mcf_rsp_type rsp_data
);

   localparam int unsigned SC = mcf_pkg::SLOT_COUNT;

   logic [SC-1:0]        sent_ff, sent_in;
   logic                 valid_ff, valid_in;
   mcf_pkg::mcf_rsp_type out_ff, out_in;

   logic [SC-1:0]        pend;
   logic [SC-1:0]        slot_bit;
   logic [SC-1:0]        rest;
   mcf_pkg::mcf_slot_type slot;
   logic                 advance;
   logic                 emit;
   mcf_pkg::mcf_rsp_type next_rsp;

   assign pend = q_head.mask & ~sent_ff;

   // lowest pending slot goes first
   always_comb begin
      slot = mcf_pkg::SLOT_VERDICT;
      for (int i = SC - 1; i >= 0; i--) begin
         if (pend[i]) begin
            slot = mcf_pkg::mcf_slot_type'(3'(i));
         end
      end
   end

   assign slot_bit = SC'(1) << slot;
   assign rest     = pend & ~slot_bit;
   assign advance  = !valid_ff || rsp_pop;
   assign emit     = advance && !q_empty;
   assign q_pop    = emit && (rest == '0);

   always_comb begin
      next_rsp             = '0;
      next_rsp.kind        = mcf_pkg::KIND_TX;
      next_rsp.verdict     = mcf_pkg::VERDICT_OK;
      next_rsp.last_of_run = 1'b0;
      unique case (slot)
         mcf_pkg::SLOT_LEN:    next_rsp.out_byte = q_head.len_byte;
         mcf_pkg::SLOT_MBOX:   next_rsp.out_byte = q_head.mailbox;
         mcf_pkg::SLOT_CMD:    next_rsp.out_byte = q_head.command;
         mcf_pkg::SLOT_SEQ:    next_rsp.out_byte = q_head.seq;
         mcf_pkg::SLOT_DATA: begin
            next_rsp.out_byte = q_head.data;
            next_rsp.kind     = q_head.rx_data ? mcf_pkg::KIND_RX : mcf_pkg::KIND_TX;
         end
         mcf_pkg::SLOT_CHK_HI: next_rsp.out_byte = q_head.check[15:8];
         mcf_pkg::SLOT_CHK_LO: begin
            next_rsp.out_byte    = q_head.check[7:0];
            next_rsp.last_of_run = 1'b1;
         end
         mcf_pkg::SLOT_VERDICT: begin
            next_rsp.kind        = mcf_pkg::KIND_VERDICT;
            next_rsp.verdict     = q_head.verdict;
            next_rsp.last_of_run = 1'b1;
         end
      endcase
   end

   always_comb begin
      sent_in  = sent_ff;
      valid_in = valid_ff;
      out_in   = out_ff;
      if (advance) begin
         valid_in = emit;
      end
      if (emit) begin
         out_in  = next_rsp;
         sent_in = q_pop ? '0 : (sent_ff | slot_bit);
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   a_head_pending: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> pend != '0)
      else $error("head command has no pending slot");

   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && out_ff.kind == mcf_pkg::KIND_VERDICT |-> out_ff.last_of_run)
      else $error("verdict without end of frame");

endmodule

### design/mailbox_command_framer_top.sv
// ----------------------------------------------------------------------------
// mailbox_command_framer_top: mailbox command framer and reply checker
// Builds request frames with sequence number and checksum, and checks reply
// frames, passing data on with a closing verdict.
//
//   channel  ports                           direction
//   req      req_push, req_full, req_data     in, queue write side
//   rsp      rsp_empty, rsp_pop, rsp_data     out, queue read side
//   csr      csr_write_en, csr_write_data     in, query command register
//
// One request transaction is taken per cycle while the command queue has
// room. The result sequencer emits one result per cycle while rsp is not
// stalled; a transmit frame start yields up to seven results, absorbed by
// the four-entry command queue. A stall on rsp backs up through the queue
// into req_full. Reset is synchronous and clears frame state, queue and the
// output valid flag.
// ----------------------------------------------------------------------------
module mailbox_command_framer_top #(
   parameter int unsigned BUFFER_BYTES = mcf_pkg::BUFFER_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  mcf_pkg::mcf_req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output mcf_pkg::mcf_rsp_type rsp_data,
   input  logic                 csr_write_en,
   input  logic [7:0]           csr_write_data
);

   logic                 q_push;
   logic                 q_full;
   logic                 q_pop;
   logic                 q_empty;
   mcf_pkg::mcf_cmd_type q_entry;
   mcf_pkg::mcf_cmd_type q_head;

   assign req_full = q_full;

   mcf_front #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data      (req_data),
      .csr_write_en  (csr_write_en),
      .csr_write_data(csr_write_data),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   mcf_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   mcf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

### bench/mailbox_command_framer_top_test.sv
// ----------------------------------------------------------------------------
// mailbox_command_framer_top_test: self-checking bench for the command framer
// Drives request frames and reply frames through the queue-style ports with
// random gaps and stalls. A cycle-free model of the framer predicts every
// result, and each popped result is compared field by field. A directed table
// covers the corner cases, then randomized frames run under several settings
// of the query command register.
// ----------------------------------------------------------------------------
module mailbox_command_framer_top_test;

   localparam int unsigned TX_LEN_MAX   = mcf_pkg::BUFFER_BYTES_DEF - mcf_pkg::TX_OVERHEAD;
   localparam int unsigned RX_LEN_MAX   = mcf_pkg::BUFFER_BYTES_DEF - mcf_pkg::RX_OVERHEAD;
   localparam logic        MODE_TX      = 1'b0;
   localparam logic        MODE_RX      = 1'b1;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          STUCK_LIMIT  = 4000;
   localparam int          PHASE_ITEMS  = 16;
   localparam int          TABLE_ROWS   = 25;
   localparam mcf_pkg::mcf_rsp_type NO_RSP =
      '{8'd0, mcf_pkg::KIND_TX, mcf_pkg::VERDICT_OK, 1'b0};

   typedef struct {
      mcf_pkg::mcf_req_type req;
      bit                   typed;
      mcf_pkg::mcf_rsp_type first;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_push = 1'b0;
   logic                 req_full;
   mcf_pkg::mcf_req_type req_data = '0;
   logic                 rsp_empty;
   logic                 rsp_pop = 1'b0;
   mcf_pkg::mcf_rsp_type rsp_data;
   logic                 csr_write_en = 1'b0;
   logic [7:0]           csr_write_data = 8'h00;

   // framer model state
   logic [7:0]  tx_seq, next_pos, body_len, cur_cmd, rx_status, rx_chk_hi, query_cmd;
   logic [15:0] sum16;
   logic        in_frame, cur_mode;

   mcf_pkg::mcf_rsp_type awaited_results[$];
   int           mismatch_count = 0;
   int           stuck_cycles = 0;
   int           frame_items = 0;
   int           hold_asks = 0;
   int           holds_done = 0;
   bit           busy_mode = 1'b0;
   stim_row_type dir_rows [TABLE_ROWS];

   mailbox_command_framer_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always #6 clock = ~clock;

   // ---------------- framer model ----------------

   task automatic add_byte(input int unsigned pos, input logic [7:0] b);
      if (pos[0]) begin
         sum16 += {b, 8'h00};
      end else begin
         sum16 += {8'h00, b};
      end
   endtask

   task automatic emit(input logic [7:0] b, input mcf_pkg::mcf_kind_type k,
                       input mcf_pkg::mcf_verdict_type v, input logic last);
      awaited_results.push_back('{b, k, v, last});
   endtask

   task automatic close_tx();
      logic [15:0] c;
      c = ~sum16;
      emit(c[15:8], mcf_pkg::KIND_TX, mcf_pkg::VERDICT_OK, 1'b0);
      emit(c[7:0], mcf_pkg::KIND_TX, mcf_pkg::VERDICT_OK, 1'b1);
      in_frame = 1'b0;
   endtask

   task automatic tx_byte(input logic [7:0] b);
      int unsigned p;
      p = next_pos;
      add_byte(p, b);
      emit(b, mcf_pkg::KIND_TX, mcf_pkg::VERDICT_OK, 1'b0);
      next_pos = 8'(p + 1);
      if (p + 1 >= 4 + body_len) close_tx();
   endtask

   task automatic rx_byte(input logic [7:0] b);
      int unsigned              p, span;
      logic [15:0]              want;
      mcf_pkg::mcf_verdict_type v;
      p = next_pos;
      span = 3 + body_len;
      next_pos = 8'(p + 1);
      if (p == 0) return;
      if (p < span) begin
         add_byte(p, b);
         if (p == 2) rx_status = b;
         if (p >= 3) emit(b, mcf_pkg::KIND_RX, mcf_pkg::VERDICT_OK, 1'b0);
      end else if (p == span) begin
         rx_chk_hi = b;
      end else begin
         want = ~sum16;
         if (want != {rx_chk_hi, b}) begin
            v = mcf_pkg::VERDICT_CSUM;
         end else if (rx_status != mcf_pkg::STATUS_OK) begin
            v = (cur_cmd == query_cmd || rx_status == mcf_pkg::STATUS_NO_DATA) ?
                mcf_pkg::VERDICT_NO_DATA : mcf_pkg::VERDICT_DEV_ERR;
         end else begin
            v = mcf_pkg::VERDICT_OK;
         end
         emit(8'h00, mcf_pkg::KIND_VERDICT, v, 1'b1);
         in_frame = 1'b0;
      end
   endtask

   task automatic frame_item(input mcf_pkg::mcf_req_type r);
      if (r.frame_start) begin
         in_frame = 1'b0;
         cur_mode = r.mode;
         cur_cmd = r.command;
         sum16 = 16'h0000;
         rx_status = mcf_pkg::STATUS_OK;
         rx_chk_hi = 8'h00;
         if (r.mode == MODE_TX) begin
            if (r.payload_len > TX_LEN_MAX) begin
               emit(8'h00, mcf_pkg::KIND_VERDICT, mcf_pkg::VERDICT_TOO_LONG, 1'b1);
            end else begin
               body_len = r.payload_len;
               add_byte(1, r.mailbox);
               add_byte(2, r.command);
               add_byte(3, tx_seq);
               emit(r.payload_len + 8'd5, mcf_pkg::KIND_TX, mcf_pkg::VERDICT_OK, 1'b0);
               emit(r.mailbox, mcf_pkg::KIND_TX, mcf_pkg::VERDICT_OK, 1'b0);
               emit(r.command, mcf_pkg::KIND_TX, mcf_pkg::VERDICT_OK, 1'b0);
               emit(tx_seq, mcf_pkg::KIND_TX, mcf_pkg::VERDICT_OK, 1'b0);
               tx_seq = tx_seq + 8'd1;
               next_pos = 8'd4;
               in_frame = 1'b1;
               if (r.payload_len == 8'd0) begin
                  close_tx();
               end else begin
                  tx_byte(r.data_byte);
               end
            end
         end else if (r.payload_len > RX_LEN_MAX) begin
            emit(8'h00, mcf_pkg::KIND_VERDICT, mcf_pkg::VERDICT_TOO_LONG, 1'b1);
         end else begin
            body_len = r.payload_len;
            next_pos = 8'd0;
            in_frame = 1'b1;
            rx_byte(r.data_byte);
         end
      end else if (in_frame && r.mode == cur_mode) begin
         if (r.mode == MODE_TX) begin
            tx_byte(r.data_byte);
         end else begin
            rx_byte(r.data_byte);
         end
      end
   endtask

   // ---------------- stimulus helpers ----------------

   function automatic int pick_gap();
      int r;
      if (busy_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic mcf_pkg::mcf_req_type rq(input logic m, input logic s,
                                               input logic [7:0] d, input logic [7:0] c,
                                               input logic [7:0] mb, input logic [7:0] l);
      return '{m, s, d, c, mb, l};
   endfunction

   function automatic mcf_pkg::mcf_req_type noise_req();
      return rq(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endfunction

   // Offer one transaction, hold it until taken, then run it through the model
   task automatic send_item(input mcf_pkg::mcf_req_type r, input bit typed,
                            input mcf_pkg::mcf_rsp_type first);
      int gap;
      int base;
      gap = pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full !== 1'b0);
      base = awaited_results.size();
      frame_item(r);
      if (typed) awaited_results[base] = first;
   endtask

   task automatic send_frame(input logic mode);
      logic [7:0]           bytes[$];
      logic [15:0]          s;
      logic [7:0]           cmd, mbox;
      int unsigned          len, lim, stop, k, r;
      mcf_pkg::mcf_req_type q;
      lim = (mode == MODE_TX) ? TX_LEN_MAX : RX_LEN_MAX;
      r = $urandom_range(0, 99);
      len = (r < 82) ? $urandom_range(0, 4) :
            (r < 98) ? $urandom_range(5, 16) : $urandom_range(lim + 1, 255);
      cmd = $urandom_range(0, 1) ? query_cmd : 8'($urandom_range(0, 255));
      mbox = 8'($urandom_range(0, 255));
      if (len > lim) begin
         // trailing bytes after a rejected header must be dropped
         repeat ($urandom_range(1, 3)) bytes.push_back(8'($urandom_range(0, 255)));
      end else if (mode == MODE_TX) begin
         repeat ((len == 0) ? 1 : len) bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         bytes.push_back(8'($urandom_range(0, 255)));
         bytes.push_back(8'($urandom_range(0, 255)));
         r = $urandom_range(0, 99);
         bytes.push_back((r < 60) ? mcf_pkg::STATUS_OK :
                         (r < 75) ? mcf_pkg::STATUS_NO_DATA :
                         8'($urandom_range(0, 255)));
         repeat (len) bytes.push_back(8'($urandom_range(0, 255)));
         s = 16'h0000;
         for (k = 1; k < bytes.size(); k++) begin
            s += k[0] ? {bytes[k], 8'h00} : {8'h00, bytes[k]};
         end
         s = ~s;
         bytes.push_back(s[15:8]);
         bytes.push_back(s[7:0]);
         if ($urandom_range(0, 99) < 10) begin
            bytes[bytes.size() - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
         end
      end
      // cut some frames short so that the next header restarts the framer
      stop = ($urandom_range(0, 99) < 8) ? $urandom_range(1, bytes.size()) : bytes.size();
      for (k = 0; k < stop; k++) begin
         q = noise_req();
         q.mode = mode;
         q.frame_start = (k == 0);
         q.data_byte = bytes[k];
         if (k == 0) begin
            q.command = cmd;
            q.mailbox = mbox;
            q.payload_len = 8'(len);
         end
         send_item(q, 1'b0, NO_RSP);
         frame_items++;
         if ($urandom_range(0, 99) < 5) begin
            q = noise_req();
            q.mode = ~mode;
            q.frame_start = 1'b0;
            send_item(q, 1'b0, NO_RSP);
         end
      end
   endtask

   // Wait until every predicted result has been popped, then let the pipe empty
   task automatic settle();
      req_push <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic note_mismatch(input string what, input mcf_pkg::mcf_rsp_type want,
                                input mcf_pkg::mcf_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%s: expected byte %02h kind %0d verdict %0d last %0b,",
                  what, want.out_byte, want.kind, want.verdict, want.last_of_run,
                  " got byte %02h kind %0d verdict %0d last %0b",
                  got.out_byte, got.kind, got.verdict, got.last_of_run);
      end
   endtask

   // ---------------- result side ----------------

   initial begin
      int stall_left;
      stall_left = 0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (holds_done < hold_asks) begin
            holds_done++;
            rsp_pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (stall_left > 0) begin
            rsp_pop <= 1'b0;
            stall_left--;
         end else begin
            rsp_pop <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      mcf_pkg::mcf_rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (awaited_results.size() == 0) begin
            note_mismatch("unexpected result", NO_RSP, rsp_data);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.kind !== want.kind ||
                rsp_data.verdict !== want.verdict ||
                rsp_data.last_of_run !== want.last_of_run) begin
               note_mismatch("result mismatch", want, rsp_data);
            end
         end
      end
   end

   // Abort when neither side moves a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("[mailbox_command_framer_top] ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // ---------------- main sequence ----------------

   initial begin
      int                   k, p, r;
      logic [7:0]           cfg;
      mcf_pkg::mcf_req_type q;

      tx_seq = 8'h00; next_pos = 8'h00; body_len = 8'h00; cur_cmd = 8'h00;
      rx_status = 8'h00; rx_chk_hi = 8'h00; query_cmd = 8'h00; sum16 = 16'h0000;
      in_frame = 1'b0; cur_mode = MODE_TX;

      dir_rows = '{
         // empty request, max mailbox: header and checksum at once
         '{rq(MODE_TX, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'd0), 1'b1,
           '{8'd5, mcf_pkg::KIND_TX, mcf_pkg::VERDICT_OK, 1'b0}},
         '{rq(MODE_TX, 1'b1, 8'h00, 8'hFF, 8'h00, 8'd250), 1'b1,
           '{8'd0, mcf_pkg::KIND_VERDICT, mcf_pkg::VERDICT_TOO_LONG, 1'b1}},
         '{rq(MODE_TX, 1'b1, 8'h00, 8'hFF, 8'h00, 8'd249), 1'b1,
           '{8'd254, mcf_pkg::KIND_TX, mcf_pkg::VERDICT_OK, 1'b0}},
         // restart abandons the long request
         '{rq(MODE_TX, 1'b1, 8'hFF, 8'h5A, 8'hA5, 8'd1), 1'b1,
           '{8'd6, mcf_pkg::KIND_TX, mcf_pkg::VERDICT_OK, 1'b0}},
         '{rq(MODE_TX, 1'b0, 8'h11, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b1, 8'h00, 8'h00, 8'h00, 8'd251), 1'b1,
           '{8'd0, mcf_pkg::KIND_VERDICT, mcf_pkg::VERDICT_TOO_LONG, 1'b1}},
         '{rq(MODE_RX, 1'b1, 8'hFF, 8'h00, 8'h00, 8'd250), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b1, 8'h07, 8'h07, 8'h00, 8'd2), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'h12, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         // transmit byte inside a reply: ignored
         '{rq(MODE_TX, 1'b0, 8'h99, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'h00, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'h34, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'h56, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'hB9, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'hA9, 8'h00, 8'h00, 8'd0), 1'b1,
           '{8'd0, mcf_pkg::KIND_VERDICT, mcf_pkg::VERDICT_OK, 1'b1}},
         '{rq(MODE_RX, 1'b1, 8'h03, 8'h07, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'h00, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'h05, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'hFF, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'hFA, 8'h00, 8'h00, 8'd0), 1'b1,
           '{8'd0, mcf_pkg::KIND_VERDICT, mcf_pkg::VERDICT_DEV_ERR, 1'b1}},
         '{rq(MODE_RX, 1'b1, 8'h05, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'h00, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'h01, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         '{rq(MODE_RX, 1'b0, 8'hFF, 8'h00, 8'h00, 8'd0), 1'b0, NO_RSP},
         // low check byte off by one
         '{rq(MODE_RX, 1'b0, 8'hFF, 8'h00, 8'h00, 8'd0), 1'b1,
           '{8'd0, mcf_pkg::KIND_VERDICT, mcf_pkg::VERDICT_CSUM, 1'b1}}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < TABLE_ROWS; k++) begin
         send_item(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].first);
      end

      // hold the result side while empty requests pile up behind it
      hold_asks++;

      // run the sequence number through its wrap with empty requests
      repeat (260) begin
         q = noise_req();
         q.mode = MODE_TX;
         q.frame_start = 1'b1;
         q.payload_len = 8'd0;
         send_item(q, 1'b0, NO_RSP);
      end

      for (p = 0; p < 4; p++) begin
         settle();
         cfg = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom_range(0, 255));
         csr_write_en <= 1'b1;
         csr_write_data <= cfg;
         @(posedge clock);
         csr_write_en <= 1'b0;
         query_cmd = cfg;
         busy_mode = (p == 2);
         frame_items = 0;
         while (frame_items < PHASE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               send_frame(MODE_TX);
            end else if (r < 90) begin
               send_frame(MODE_RX);
            end else begin
               repeat ($urandom_range(1, 3)) send_item(noise_req(), 1'b0, NO_RSP);
            end
         end
      end

      settle();
      if (mismatch_count == 0) begin
         $display("[mailbox_command_framer_top] OK");
      end else begin
         $display("[mailbox_command_framer_top] ERROR");
      end
      $finish;
   end

endmodule
